// File: hw/rtl/qbvs_pkg.sv
// Shared types, codes and constants of the quad batch vertex setup block.
package qbvs_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int TEXTURE_SLOTS = 32;
  localparam int SLOT_W        = 5;
  localparam int USED_W        = 6;
  localparam int CNT_W         = 15;
  localparam int WORD_W        = 32;
  localparam int ACC_W         = 64;
  localparam int IDX_W         = 16;
  localparam int STEP_W        = 3;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 15;
  localparam int IN_DATA_W     = 256;
  localparam int IN_USER_W     = 2;
  localparam int OUT_DATA_W    = 168;
  localparam int OUT_USER_W    = 3;

  localparam logic [CNT_W-1:0]  QPB_RESET        = CNT_W'(10000);
  localparam logic [USED_W-1:0] SLOT_LIMIT_RESET = USED_W'(32);

  localparam logic [CFG_IDX_W-1:0] CFG_QUADS_PER_BATCH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LIMIT      = 1'b1;

  localparam logic [STEP_W-1:0] STEP_MUL_X  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_MUL_Y  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_SUM_X  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_SUM_XY = 3'd3;
  localparam logic [STEP_W-1:0] STEP_SUM_Y  = 3'd4;
  localparam logic [STEP_W-1:0] CORNER_LAST = 3'd3;
  localparam logic [STEP_W-1:0] INDEX_LAST  = 3'd5;

  typedef enum logic [1:0] {
    KIND_FLAT,
    KIND_TEX,
    KIND_END,
    KIND_BEGIN
  } kind_t;

  typedef enum logic [1:0] {
    RES_VERTEX,
    RES_INDEX,
    RES_FLUSH,
    RES_BIND
  } res_kind_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_CALC,
    OP_FLUSH,
    OP_BIND,
    OP_VERT,
    OP_INDEX
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_CALC,
    ST_FULL,
    ST_SLOTCHK,
    ST_SLOTFLUSH,
    ST_BIND,
    ST_VERT,
    ST_INDEX,
    ST_END_FLAT,
    ST_END_TEX
  } state_t;

  typedef struct packed {
    op_t               op;
    logic              fire;
    logic              emit;
    logic              last;
    logic              sel;
    logic [STEP_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  full;
    logic  flat_nz;
    logic  tex_nz;
    logic  hit;
    logic  slot_full;
    logic  out_free;
  } stat_t;

  function automatic logic [1:0] index_offset(input logic [STEP_W-1:0] step);
    logic [1:0] off;
    case (step)
      3'd0:    off = 2'd0;
      3'd1:    off = 2'd1;
      3'd2:    off = 2'd2;
      3'd3:    off = 2'd2;
      3'd4:    off = 2'd3;
      default: off = 2'd0;
    endcase
    return off;
  endfunction

endpackage

// File: hw/rtl/qbvs_ctrl.sv
// Sequencer of the quad batch vertex setup block: accept, compute, flush, bind, emit.
module qbvs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  qbvs_pkg::stat_t   stat,
  output qbvs_pkg::cmd_t    cmd
);

  qbvs_pkg::state_t                state_r, state_nxt;
  logic [qbvs_pkg::STEP_W-1:0]     step_r, step_nxt;
  logic                            sel;

  assign sel = (stat.kind == qbvs_pkg::KIND_TEX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qbvs_pkg::ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    in_tready = 1'b0;
    cmd.op    = qbvs_pkg::OP_NONE;
    cmd.fire  = 1'b0;
    cmd.emit  = 1'b0;
    cmd.last  = 1'b0;
    cmd.sel   = sel;
    cmd.step  = step_r;
    unique case (state_r)
      qbvs_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.op    = qbvs_pkg::OP_LOAD;
        cmd.fire  = in_tvalid;
        if (in_tvalid) begin
          state_nxt = qbvs_pkg::ST_DISPATCH;
        end
      end
      qbvs_pkg::ST_DISPATCH: begin
        step_nxt = '0;
        if (stat.kind == qbvs_pkg::KIND_BEGIN) begin
          cmd.op    = qbvs_pkg::OP_CLEAR;
          cmd.fire  = 1'b1;
          state_nxt = qbvs_pkg::ST_IDLE;
        end else if (stat.kind == qbvs_pkg::KIND_END) begin
          state_nxt = qbvs_pkg::ST_END_FLAT;
        end else begin
          state_nxt = qbvs_pkg::ST_CALC;
        end
      end
      qbvs_pkg::ST_CALC: begin
        cmd.op   = qbvs_pkg::OP_CALC;
        cmd.fire = 1'b1;
        step_nxt = step_r + 3'd1;
        if (step_r == qbvs_pkg::STEP_SUM_Y) begin
          step_nxt = '0;
          if (stat.full) begin
            state_nxt = qbvs_pkg::ST_FULL;
          end else if (sel) begin
            state_nxt = qbvs_pkg::ST_SLOTCHK;
          end else begin
            state_nxt = qbvs_pkg::ST_VERT;
          end
        end
      end
      qbvs_pkg::ST_FULL: begin
        cmd.op   = qbvs_pkg::OP_FLUSH;
        cmd.emit = sel ? stat.tex_nz : stat.flat_nz;
        cmd.fire = !cmd.emit || stat.out_free;
        if (cmd.fire) begin
          state_nxt = sel ? qbvs_pkg::ST_SLOTCHK : qbvs_pkg::ST_VERT;
        end
      end
      qbvs_pkg::ST_SLOTCHK: begin
        if (stat.hit) begin
          state_nxt = qbvs_pkg::ST_VERT;
        end else if (stat.slot_full) begin
          state_nxt = qbvs_pkg::ST_SLOTFLUSH;
        end else begin
          state_nxt = qbvs_pkg::ST_BIND;
        end
      end
      qbvs_pkg::ST_SLOTFLUSH: begin
        cmd.op   = qbvs_pkg::OP_FLUSH;
        cmd.sel  = 1'b1;
        cmd.emit = stat.tex_nz;
        cmd.fire = !cmd.emit || stat.out_free;
        if (cmd.fire) begin
          state_nxt = qbvs_pkg::ST_BIND;
        end
      end
      qbvs_pkg::ST_BIND: begin
        cmd.op   = qbvs_pkg::OP_BIND;
        cmd.sel  = 1'b1;
        cmd.emit = 1'b1;
        cmd.fire = stat.out_free;
        if (cmd.fire) begin
          state_nxt = qbvs_pkg::ST_VERT;
        end
      end
      qbvs_pkg::ST_VERT: begin
        cmd.op   = qbvs_pkg::OP_VERT;
        cmd.emit = 1'b1;
        cmd.fire = stat.out_free;
        if (cmd.fire) begin
          step_nxt = step_r + 3'd1;
          if (step_r == qbvs_pkg::CORNER_LAST) begin
            step_nxt  = '0;
            state_nxt = qbvs_pkg::ST_INDEX;
          end
        end
      end
      qbvs_pkg::ST_INDEX: begin
        cmd.op   = qbvs_pkg::OP_INDEX;
        cmd.emit = 1'b1;
        cmd.last = (step_r == qbvs_pkg::INDEX_LAST);
        cmd.fire = stat.out_free;
        if (cmd.fire) begin
          step_nxt = step_r + 3'd1;
          if (step_r == qbvs_pkg::INDEX_LAST) begin
            step_nxt  = '0;
            state_nxt = qbvs_pkg::ST_IDLE;
          end
        end
      end
      qbvs_pkg::ST_END_FLAT: begin
        cmd.op   = qbvs_pkg::OP_FLUSH;
        cmd.sel  = 1'b0;
        cmd.emit = stat.flat_nz;
        cmd.last = !stat.tex_nz;
        cmd.fire = !cmd.emit || stat.out_free;
        if (cmd.fire) begin
          state_nxt = qbvs_pkg::ST_END_TEX;
        end
      end
      qbvs_pkg::ST_END_TEX: begin
        cmd.op   = qbvs_pkg::OP_FLUSH;
        cmd.sel  = 1'b1;
        cmd.emit = stat.tex_nz;
        cmd.last = 1'b1;
        cmd.fire = !cmd.emit || stat.out_free;
        if (cmd.fire) begin
          state_nxt = qbvs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = qbvs_pkg::ST_IDLE;
        step_nxt  = '0;
      end
    endcase
  end

endmodule

// File: hw/rtl/qbvs_dp.sv
// Datapath: input hold, vertex arithmetic, batch counters, texture slot table, result register.
module qbvs_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [qbvs_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic [qbvs_pkg::IN_USER_W-1:0]      in_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [qbvs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [qbvs_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [qbvs_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [qbvs_pkg::OUT_USER_W-1:0]     out_tuser,
  output logic                                out_tlast,
  input  qbvs_pkg::cmd_t                      cmd,
  output qbvs_pkg::stat_t                     stat
);

  localparam logic signed [qbvs_pkg::ACC_W-1:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [qbvs_pkg::ACC_W-1:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

  function automatic logic [qbvs_pkg::WORD_W-1:0] saturate(
    input logic signed [qbvs_pkg::ACC_W-1:0] v
  );
    logic [qbvs_pkg::WORD_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[qbvs_pkg::WORD_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[qbvs_pkg::WORD_W-1:0];
    end else begin
      r = v[qbvs_pkg::WORD_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [qbvs_pkg::SLOT_W-1:0] first_set(
    input logic [qbvs_pkg::TEXTURE_SLOTS-1:0] v
  );
    logic [qbvs_pkg::SLOT_W-1:0] idx;
    idx = '0;
    for (int i = qbvs_pkg::TEXTURE_SLOTS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = qbvs_pkg::SLOT_W'(i);
      end
    end
    return idx;
  endfunction

  // held input item
  qbvs_pkg::kind_t                    kind_r;
  logic signed [qbvs_pkg::WORD_W-1:0] pos_x_r, pos_y_r, size_w_r, size_h_r;
  logic signed [qbvs_pkg::WORD_W-1:0] anchor_x_r, anchor_y_r;
  logic [qbvs_pkg::WORD_W-1:0]        color_r, tex_r;

  // arithmetic
  logic signed [qbvs_pkg::WORD_W-1:0] mul_a, mul_b;
  logic signed [qbvs_pkg::ACC_W-1:0]  mul_p;
  logic signed [qbvs_pkg::ACC_W-1:0]  prod_r, neg_r;
  logic signed [qbvs_pkg::ACC_W-1:0]  bx0_r, bx1_r, by0_r, by1_r;

  // batch and slot state
  logic [qbvs_pkg::CNT_W-1:0]         qpb_r, flat_r, tex_cnt_r;
  logic [qbvs_pkg::CNT_W-1:0]         flat_nxt, tex_cnt_nxt, cnt_sel;
  logic [qbvs_pkg::USED_W-1:0]        slot_limit_r, used_r, used_nxt, slot_lim;
  logic                               hit_r, hit_nxt;
  logic [qbvs_pkg::TEXTURE_SLOTS-1:0] hitv_r;
  logic [qbvs_pkg::SLOT_W-1:0]        slot_r, bind_slot;
  logic [qbvs_pkg::WORD_W-1:0]        tex_mem [qbvs_pkg::TEXTURE_SLOTS];

  // result register
  logic                               out_valid_r, out_free, out_load;
  qbvs_pkg::res_kind_t                res_kind_r, res_kind_nxt;
  logic                               batch_r, batch_nxt, last_r;
  logic [qbvs_pkg::WORD_W-1:0]        vx_r, vx_nxt, vy_r, vy_nxt;
  logic [qbvs_pkg::WORD_W-1:0]        vcol_r, vcol_nxt, bind_r, bind_nxt;
  logic [qbvs_pkg::SLOT_W-1:0]        snum_r, snum_nxt;
  logic [1:0]                         corner_r, corner_nxt;
  logic [qbvs_pkg::IDX_W-1:0]         index_r, index_nxt;
  logic [qbvs_pkg::CNT_W-1:0]         fq_r, fq_nxt;
  logic                               cx, cy;

  assign cfg_ready = 1'b1;

  assign mul_a = (cmd.step == qbvs_pkg::STEP_MUL_X) ? anchor_x_r : anchor_y_r;
  assign mul_b = (cmd.step == qbvs_pkg::STEP_MUL_X) ? size_w_r : size_h_r;
  assign mul_p = mul_a * mul_b;

  assign cnt_sel   = (kind_r == qbvs_pkg::KIND_TEX) ? tex_cnt_r : flat_r;
  assign slot_lim  = (slot_limit_r < qbvs_pkg::USED_W'(qbvs_pkg::TEXTURE_SLOTS)) ?
                     slot_limit_r : qbvs_pkg::USED_W'(qbvs_pkg::TEXTURE_SLOTS);
  assign bind_slot = (used_r >= qbvs_pkg::USED_W'(qbvs_pkg::TEXTURE_SLOTS)) ?
                     qbvs_pkg::SLOT_W'(qbvs_pkg::TEXTURE_SLOTS - 1) :
                     used_r[qbvs_pkg::SLOT_W-1:0];

  assign out_free = !out_valid_r || out_tready;
  assign out_load = cmd.fire && cmd.emit;

  assign stat.kind      = kind_r;
  assign stat.full      = (cnt_sel >= qpb_r);
  assign stat.flat_nz   = (flat_r != '0);
  assign stat.tex_nz    = (tex_cnt_r != '0);
  assign stat.hit       = hit_r;
  assign stat.slot_full = (used_r >= slot_lim);
  assign stat.out_free  = out_free;

  // hold input beat
  always_ff @(posedge clk) begin
    if (cmd.fire && cmd.op == qbvs_pkg::OP_LOAD) begin
      kind_r     <= qbvs_pkg::kind_t'(in_tuser);
      pos_x_r    <= in_tdata[31:0];
      pos_y_r    <= in_tdata[63:32];
      size_w_r   <= in_tdata[95:64];
      size_h_r   <= in_tdata[127:96];
      anchor_x_r <= in_tdata[159:128];
      anchor_y_r <= in_tdata[191:160];
      color_r    <= in_tdata[223:192];
      tex_r      <= in_tdata[255:224];
    end
  end

  // corner 0 term is floor(-a*s) + p; corner 1 adds the size itself
  always_ff @(posedge clk) begin
    if (cmd.fire && cmd.op == qbvs_pkg::OP_CALC) begin
      case (cmd.step)
        qbvs_pkg::STEP_MUL_X: begin
          prod_r <= mul_p;
          for (int i = 0; i < qbvs_pkg::TEXTURE_SLOTS; i++) begin
            hitv_r[i] <= (tex_mem[i] == tex_r) && (qbvs_pkg::USED_W'(i) < used_r);
          end
        end
        qbvs_pkg::STEP_MUL_Y: begin
          prod_r <= mul_p;
          neg_r  <= -prod_r;
          slot_r <= first_set(hitv_r);
        end
        qbvs_pkg::STEP_SUM_X: begin
          bx0_r <= (neg_r >>> qbvs_pkg::FRAC_BITS) + qbvs_pkg::ACC_W'(pos_x_r);
          neg_r <= -prod_r;
        end
        qbvs_pkg::STEP_SUM_XY: begin
          bx1_r <= bx0_r + qbvs_pkg::ACC_W'(size_w_r);
          by0_r <= (neg_r >>> qbvs_pkg::FRAC_BITS) + qbvs_pkg::ACC_W'(pos_y_r);
        end
        qbvs_pkg::STEP_SUM_Y: begin
          by1_r <= by0_r + qbvs_pkg::ACC_W'(size_h_r);
        end
        default: begin
        end
      endcase
    end else if (cmd.fire && cmd.op == qbvs_pkg::OP_BIND) begin
      slot_r <= bind_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fire && cmd.op == qbvs_pkg::OP_BIND) begin
      tex_mem[bind_slot] <= tex_r;
    end
  end

  always_comb begin
    flat_nxt    = flat_r;
    tex_cnt_nxt = tex_cnt_r;
    used_nxt    = used_r;
    hit_nxt     = hit_r;
    if (cmd.fire) begin
      case (cmd.op)
        qbvs_pkg::OP_CLEAR: begin
          flat_nxt    = '0;
          tex_cnt_nxt = '0;
          used_nxt    = '0;
          hit_nxt     = 1'b0;
        end
        qbvs_pkg::OP_CALC: begin
          if (cmd.step == qbvs_pkg::STEP_MUL_Y) begin
            hit_nxt = |hitv_r;
          end
        end
        qbvs_pkg::OP_FLUSH: begin
          if (cmd.sel) begin
            tex_cnt_nxt = '0;
            used_nxt    = '0;
            hit_nxt     = 1'b0;
          end else begin
            flat_nxt = '0;
          end
        end
        qbvs_pkg::OP_BIND: begin
          used_nxt = qbvs_pkg::USED_W'(bind_slot) + 6'd1;
        end
        qbvs_pkg::OP_INDEX: begin
          if (cmd.step == qbvs_pkg::INDEX_LAST) begin
            if (cmd.sel) begin
              tex_cnt_nxt = tex_cnt_r + 15'd1;
            end else begin
              flat_nxt = flat_r + 15'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qpb_r        <= qbvs_pkg::QPB_RESET;
      slot_limit_r <= qbvs_pkg::SLOT_LIMIT_RESET;
      flat_r       <= '0;
      tex_cnt_r    <= '0;
      used_r       <= '0;
      hit_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          qbvs_pkg::CFG_QUADS_PER_BATCH: qpb_r <= cfg_data[qbvs_pkg::CNT_W-1:0];
          qbvs_pkg::CFG_SLOT_LIMIT:      slot_limit_r <= cfg_data[qbvs_pkg::USED_W-1:0];
          default: begin
          end
        endcase
      end
      flat_r    <= flat_nxt;
      tex_cnt_r <= tex_cnt_nxt;
      used_r    <= used_nxt;
      hit_r     <= hit_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign cx = (cmd.step[1:0] == 2'd1) || (cmd.step[1:0] == 2'd2);
  assign cy = cmd.step[1];

  always_comb begin
    res_kind_nxt = qbvs_pkg::RES_VERTEX;
    batch_nxt    = cmd.sel;
    vx_nxt       = '0;
    vy_nxt       = '0;
    vcol_nxt     = '0;
    snum_nxt     = '0;
    corner_nxt   = '0;
    index_nxt    = '0;
    fq_nxt       = '0;
    bind_nxt     = '0;
    unique case (cmd.op)
      qbvs_pkg::OP_FLUSH: begin
        res_kind_nxt = qbvs_pkg::RES_FLUSH;
        fq_nxt       = cmd.sel ? tex_cnt_r : flat_r;
      end
      qbvs_pkg::OP_BIND: begin
        res_kind_nxt = qbvs_pkg::RES_BIND;
        snum_nxt     = bind_slot;
        bind_nxt     = tex_r;
      end
      qbvs_pkg::OP_VERT: begin
        res_kind_nxt = qbvs_pkg::RES_VERTEX;
        vx_nxt       = saturate(cx ? bx1_r : bx0_r);
        vy_nxt       = saturate(cy ? by1_r : by0_r);
        vcol_nxt     = cmd.sel ? '0 : color_r;
        snum_nxt     = cmd.sel ? slot_r : '0;
        corner_nxt   = cmd.step[1:0];
      end
      qbvs_pkg::OP_INDEX: begin
        res_kind_nxt = qbvs_pkg::RES_INDEX;
        index_nxt    = {cnt_sel[qbvs_pkg::IDX_W-3:0], 2'b00} +
                       qbvs_pkg::IDX_W'(qbvs_pkg::index_offset(cmd.step));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_kind_r <= res_kind_nxt;
      batch_r    <= batch_nxt;
      last_r     <= cmd.last;
      vx_r       <= vx_nxt;
      vy_r       <= vy_nxt;
      vcol_r     <= vcol_nxt;
      snum_r     <= snum_nxt;
      corner_r   <= corner_nxt;
      index_r    <= index_nxt;
      fq_r       <= fq_nxt;
      bind_r     <= bind_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, bind_r, fq_r, index_r, corner_r, snum_r, vcol_r, vy_r, vx_r};
  assign out_tuser  = {batch_r, res_kind_r};
  assign out_tlast  = last_r;

endmodule

// File: hw/rtl/quad_batch_vertex_setup.sv
// Top level of the quad batch vertex setup block: sequencer plus datapath.
// A quad is accepted, dispatched and worked through five arithmetic steps, then emits its results;
// slot check, batch flush and slot flush each add a state of their own when they are needed.
// End of scene flushes the flat batch, then the textured one; begin of scene clears both; each result is registered.
// The 32x32 multiplier is shared by x and y; results leave one beat per cycle at most.
// Reset clears both batches and the slot fill count and loads 10000 quads and 32 slots.
module quad_batch_vertex_setup (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // pos_x, pos_y, size_w, size_h, anchor_x, anchor_y, color_rgba, texture_id
  input  logic [qbvs_pkg::IN_DATA_W-1:0]    in_tdata,
  // kind
  input  logic [qbvs_pkg::IN_USER_W-1:0]    in_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [qbvs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [qbvs_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // vertex_x, vertex_y, vertex_color, slot_number, corner, index_value,
  // flush_quads, bind_texture, two zero bits
  output logic [qbvs_pkg::OUT_DATA_W-1:0]   out_tdata,
  // result_kind, batch_sel
  output logic [qbvs_pkg::OUT_USER_W-1:0]   out_tuser,
  output logic                              out_tlast
);

  qbvs_pkg::cmd_t  cmd;
  qbvs_pkg::stat_t stat;

  qbvs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  qbvs_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

// File: bench/quad_batch_vertex_setup_check.sv
// Checker for quad_batch_vertex_setup: predicts every result beat and compares it on the way out.
module quad_batch_vertex_setup_check (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  // pos_x, pos_y, size_w, size_h, anchor_x, anchor_y, color_rgba, texture_id
  input  logic [qbvs_pkg::IN_DATA_W-1:0]    in_tdata,
  // kind
  input  logic [qbvs_pkg::IN_USER_W-1:0]    in_tuser,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [qbvs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [qbvs_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  // vertex_x, vertex_y, vertex_color, slot_number, corner, index_value,
  // flush_quads, bind_texture, two zero bits
  input  logic [qbvs_pkg::OUT_DATA_W-1:0]   out_tdata,
  // result_kind, batch_sel
  input  logic [qbvs_pkg::OUT_USER_W-1:0]   out_tuser,
  input  logic                              out_tlast,
  output int                                fail_count,
  output int                                pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import qbvs_pkg::*;

  typedef struct packed {
    res_kind_t   kind;
    logic        sel;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] color;
    logic [4:0]  slot;
    logic [1:0]  corner;
    logic [15:0] idx;
    logic [14:0] flush_n;
    logic [31:0] bind_tex;
    logic        last;
  } result_t;

  result_t     due_results[$];
  logic [14:0] quads_limit;
  logic [5:0]  slot_cap;
  logic [14:0] flat_count;
  logic [14:0] tex_count;
  logic [31:0] slot_tex [TEXTURE_SLOTS];
  int          slots_taken;
  int          errors;

  function automatic logic [31:0] vertex_coord(input logic cbit, input logic signed [31:0] anchor,
                                               input logic signed [31:0] size,
                                               input logic signed [31:0] pos);
    longint diff;
    longint sum;
    diff = (cbit ? (longint'(1) <<< FRAC_BITS) : longint'(0)) - longint'(anchor);
    sum  = ((diff * longint'(size)) >>> FRAC_BITS) + longint'(pos);
    if (sum > longint'(32'sh7fff_ffff)) sum = longint'(32'sh7fff_ffff);
    if (sum < longint'(32'sh8000_0000)) sum = longint'(32'sh8000_0000);
    return sum[31:0];
  endfunction

  task automatic flush_batch(input logic s);
    result_t r;
    if ((s ? tex_count : flat_count) != '0) begin
      r         = '0;
      r.kind    = RES_FLUSH;
      r.sel     = s;
      r.flush_n = s ? tex_count : flat_count;
      due_results.push_back(r);
    end
    if (s) begin
      tex_count   = '0;
      slots_taken = 0;
    end else begin
      flat_count = '0;
    end
  endtask

  task automatic expand_request(input logic [IN_USER_W-1:0] k, input logic [IN_DATA_W-1:0] d);
    int          start;
    int          slot_now;
    int          cap;
    int          i;
    int          c;
    int          j;
    int          off;
    bit          hit;
    logic        s;
    logic [14:0] cnt;
    logic [15:0] base;
    logic [31:0] tex;
    result_t     r;
    start = due_results.size();
    case (k)
      KIND_BEGIN: begin
        flat_count  = '0;
        tex_count   = '0;
        slots_taken = 0;
      end
      KIND_END: begin
        flush_batch(1'b0);
        flush_batch(1'b1);
      end
      default: begin
        s = (k == KIND_TEX);
        if ((s ? tex_count : flat_count) >= quads_limit) flush_batch(s);
        slot_now = 0;
        if (s) begin
          tex = d[255:224];
          cap = (slot_cap < TEXTURE_SLOTS) ? int'(slot_cap) : TEXTURE_SLOTS;
          hit = 1'b0;
          for (i = 0; i < slots_taken; i++) begin
            if (!hit && slot_tex[i] == tex) begin
              slot_now = i;
              hit      = 1'b1;
            end
          end
          if (!hit) begin
            if (slots_taken >= cap) flush_batch(1'b1);
            slot_now           = slots_taken;
            slot_tex[slot_now] = tex;
            slots_taken        = slot_now + 1;
            r          = '0;
            r.kind     = RES_BIND;
            r.sel      = 1'b1;
            r.slot     = slot_now[4:0];
            r.bind_tex = tex;
            due_results.push_back(r);
          end
        end
        for (c = 0; c < 4; c++) begin
          r        = '0;
          r.kind   = RES_VERTEX;
          r.sel    = s;
          r.vx     = vertex_coord(c == 1 || c == 2, d[159:128], d[95:64], d[31:0]);
          r.vy     = vertex_coord(c >= 2, d[191:160], d[127:96], d[63:32]);
          r.color  = s ? 32'h0 : d[223:192];
          r.slot   = s ? slot_now[4:0] : 5'd0;
          r.corner = c[1:0];
          due_results.push_back(r);
        end
        cnt  = s ? tex_count : flat_count;
        base = {cnt[13:0], 2'b00};
        for (j = 0; j < 6; j++) begin
          off    = (j == 5) ? 0 : (j >= 3) ? j - 1 : j;
          r      = '0;
          r.kind = RES_INDEX;
          r.sel  = s;
          r.idx  = base + off[15:0];
          due_results.push_back(r);
        end
        if (s) tex_count = cnt + 15'd1;
        else flat_count = cnt + 15'd1;
      end
    endcase
    if (due_results.size() > start) begin
      r      = due_results.pop_back();
      r.last = 1'b1;
      due_results.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  task automatic compare_beat();
    result_t want;
    if (due_results.size() == 0) begin
      $error("result beat with nothing expected: kind %0h data %0h", out_tuser, out_tdata);
      errors++;
    end else begin
      want = due_results.pop_front();
      check_field("result_kind", want.kind, out_tuser[1:0]);
      check_field("batch_sel", want.sel, out_tuser[2]);
      check_field("vertex_x", want.vx, out_tdata[31:0]);
      check_field("vertex_y", want.vy, out_tdata[63:32]);
      check_field("vertex_color", want.color, out_tdata[95:64]);
      check_field("slot_number", want.slot, out_tdata[100:96]);
      check_field("corner", want.corner, out_tdata[102:101]);
      check_field("index_value", want.idx, out_tdata[118:103]);
      check_field("flush_quads", want.flush_n, out_tdata[133:119]);
      check_field("bind_texture", want.bind_tex, out_tdata[165:134]);
      check_field("pad", 32'h0, out_tdata[167:166]);
      check_field("last", want.last, out_tlast);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      quads_limit = QPB_RESET;
      slot_cap    = SLOT_LIMIT_RESET;
      flat_count  = '0;
      tex_count   = '0;
      slots_taken = 0;
      due_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_QUADS_PER_BATCH) quads_limit = cfg_data;
        else slot_cap = cfg_data[5:0];
      end
      if (in_tvalid && in_tready) expand_request(in_tuser, in_tdata);
      if (out_tvalid && out_tready) compare_beat();
    end
    pending    <= due_results.size();
    fail_count <= errors;
  end

endmodule

// File: bench/quad_batch_vertex_setup_test.sv
// Top of the quad_batch_vertex_setup testbench: clock, reset, stimulus and verdict.
module quad_batch_vertex_setup_test;
  timeunit 1ns;
  timeprecision 1ps;
  import qbvs_pkg::*;

  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_WAIT  = 32;
  localparam int PHASE_ITEMS  = 57;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [IN_USER_W-1:0]  in_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tlast;
  int                    fail_count;
  int                    pending;
  bit                    gaps;
  bit                    hold_req;
  logic [31:0]           tex_pool [40];

  quad_batch_vertex_setup dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  quad_batch_vertex_setup_check checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 11))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0;
      3, 4:    return $urandom();
      default: return $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_size();
    logic [31:0] v;
    v = $urandom_range(32'h0000_0100, 32'h0040_0000);
    case ($urandom_range(0, 7))
      0:       return pick_word();
      1:       return -v;
      default: return v;
    endcase
  endfunction

  function automatic logic [31:0] pick_anchor();
    case ($urandom_range(0, 7))
      0:       return 32'h0;
      1:       return 32'h8000;
      2:       return 32'h1_0000;
      3:       return pick_word();
      default: return $urandom_range(0, 32'h1_0000);
    endcase
  endfunction

  task automatic send_quad(input kind_t k, input logic [31:0] px, input logic [31:0] py,
                           input logic [31:0] sw, input logic [31:0] sh,
                           input logic [31:0] ax, input logic [31:0] ay,
                           input logic [31:0] col, input logic [31:0] tex);
    if (gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {tex, col, ay, ax, sh, sw, py, px};
    in_tuser  <= k;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_random(input int span);
    kind_t       k;
    logic [31:0] tex;
    int          roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) k = KIND_FLAT;
    else if (roll < 88) k = KIND_TEX;
    else if (roll < 96) k = KIND_END;
    else k = KIND_BEGIN;
    tex = ($urandom_range(0, 9) == 0) ? $urandom() : tex_pool[$urandom_range(0, span)];
    send_quad(k, pick_word(), pick_word(), pick_size(), pick_size(), pick_anchor(),
              pick_anchor(), $urandom(), tex);
  endtask

  // drop the input and wait for every outstanding result, then let the block go quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_WAIT) @(negedge clk);
  endtask

  task automatic set_limits(input logic [14:0] qpb, input logic [5:0] cap);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_QUADS_PER_BATCH;
    cfg_data  <= qpb;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index <= CFG_SLOT_LIMIT;
    cfg_data  <= {9'b0, cap};
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : sink
    bit held;
    held       = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_tready <= 1'b1;
      end else if (gaps && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("quad_batch_vertex_setup_test failed");
    $finish;
  end

  initial begin : stimulus
    int          phase;
    int          n;
    int          span;
    logic [14:0] qpb;
    logic [5:0]  cap;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    gaps      = 1'b1;
    hold_req  = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // saturation, rounding toward minus infinity, slot hits and misses, scene commands
    send_quad(KIND_FLAT, 0, 0, 0, 0, 0, 0, 32'h0, 32'h0);
    send_quad(KIND_FLAT, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
              32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff);
    send_quad(KIND_FLAT, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
              32'h7fff_ffff, 32'h7fff_ffff, 32'h1234_5678, 32'h0);
    send_quad(KIND_FLAT, 32'h1_0000, 32'h2_0000, 32'h3, -32'sd3, 32'h1, 32'h1,
              32'h00ff_00ff, 32'h0);
    send_quad(KIND_FLAT, 32'h8000_0000, 32'h0, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000, 32'hff00_ff00, 32'h0);
    send_quad(KIND_TEX, 32'h10_0000, 32'h20_0000, 32'h4_0000, 32'h2_0000, 32'h8000, 32'h8000,
              32'hdead_beef, 32'hcafe_0001);
    send_quad(KIND_TEX, 32'h11_0000, 32'h21_0000, 32'h4_0000, 32'h2_0000, 32'h8000, 32'h8000,
              32'h0, 32'hcafe_0001);
    send_quad(KIND_TEX, 32'h0, 32'h0, 32'h1_0000, 32'h1_0000, 32'h0, 32'h1_0000,
              32'h0, 32'hffff_ffff);
    send_quad(KIND_TEX, 32'h5, 32'h7, 32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h0,
              32'h0, 32'h0);
    send_quad(KIND_END, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
              $urandom(), $urandom(), $urandom());
    send_quad(KIND_END, 0, 0, 0, 0, 0, 0, 32'h0, 32'h0);
    send_quad(KIND_FLAT, 32'h3_0000, 32'h3_0000, 32'h1_0000, 32'h1_0000, 0, 0, 32'h1, 32'h0);
    send_quad(KIND_BEGIN, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
              $urandom(), $urandom(), $urandom());
    send_quad(KIND_END, 0, 0, 0, 0, 0, 0, 32'h0, 32'h0);

    settle();
    set_limits(15'd3, 6'd1);
    send_quad(KIND_TEX, 0, 0, 32'h1_0000, 32'h1_0000, 0, 0, 32'h0, 32'haaaa_0001);
    send_quad(KIND_TEX, 0, 0, 32'h1_0000, 32'h1_0000, 0, 0, 32'h0, 32'hbbbb_0002);
    send_quad(KIND_TEX, 0, 0, 32'h1_0000, 32'h1_0000, 0, 0, 32'h0, 32'hbbbb_0002);
    send_quad(KIND_TEX, 0, 0, 32'h1_0000, 32'h1_0000, 0, 0, 32'h0, 32'hbbbb_0002);
    send_quad(KIND_TEX, 0, 0, 32'h1_0000, 32'h1_0000, 0, 0, 32'h0, 32'hbbbb_0002);
    send_quad(KIND_FLAT, 0, 0, 32'h1_0000, 32'h1_0000, 0, 0, 32'h11, 32'h0);
    send_quad(KIND_FLAT, 0, 0, 32'h1_0000, 32'h1_0000, 0, 0, 32'h22, 32'h0);
    send_quad(KIND_FLAT, 0, 0, 32'h1_0000, 32'h1_0000, 0, 0, 32'h33, 32'h0);
    send_quad(KIND_FLAT, 0, 0, 32'h1_0000, 32'h1_0000, 0, 0, 32'h44, 32'h0);

    settle();
    set_limits(15'd0, 6'd0);
    send_quad(KIND_FLAT, 0, 0, 32'h1_0000, 32'h1_0000, 0, 0, 32'h55, 32'h0);
    send_quad(KIND_FLAT, 0, 0, 32'h1_0000, 32'h1_0000, 0, 0, 32'h66, 32'h0);
    send_quad(KIND_TEX, 0, 0, 32'h1_0000, 32'h1_0000, 0, 0, 32'h0, 32'hcccc_0003);
    send_quad(KIND_TEX, 0, 0, 32'h1_0000, 32'h1_0000, 0, 0, 32'h0, 32'hcccc_0003);
    send_quad(KIND_END, 0, 0, 0, 0, 0, 0, 32'h0, 32'h0);

    for (phase = 0; phase < 8; phase++) begin
      settle();
      case (phase)
        0:       begin qpb = 15'd10000; cap = 6'd32; end
        1:       begin qpb = 15'd3;     cap = 6'd2;  end
        2:       begin qpb = 15'd1;     cap = 6'd1;  end
        3:       begin qpb = 15'd16384; cap = 6'd63; end
        4:       begin qpb = 15'd0;     cap = 6'd5;  end
        5:       begin qpb = 15'd32767; cap = 6'd33; end
        6:       begin qpb = 15'd6;     cap = 6'd4;  end
        default: begin qpb = 15'd2;     cap = 6'd32; end
      endcase
      set_limits(qpb, cap);
      foreach (tex_pool[i]) tex_pool[i] = $urandom();
      span = (cap > 6'd36) ? 39 : int'(cap) + 3;
      gaps = !(phase == 3 || phase == 7);
      if (phase == 0) hold_req = 1'b1;
      for (n = 0; n < PHASE_ITEMS; n++) send_random(span);
    end

    settle();
    if (fail_count == 0) $display("quad_batch_vertex_setup_test passed");
    else $display("quad_batch_vertex_setup_test failed");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/qbvs_pkg.sv
hw/rtl/qbvs_ctrl.sv
hw/rtl/qbvs_dp.sv
hw/rtl/quad_batch_vertex_setup.sv
bench/quad_batch_vertex_setup_check.sv
bench/quad_batch_vertex_setup_test.sv
